>>> sv/htds_pkg.sv
// Package for the haptic tremor drive sequencer.
// Holds the channel word types, register index codes and driver constants.
// No dependencies.
package htds_pkg;

    // Field widths fixed by the channel format.
    localparam int RMS_W  = 10;
    localparam int NOW_W  = 32;
    localparam int BYTE_W = 8;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BRAKE      = 2'd3;

    localparam logic [RMS_W-1:0]      THRESHOLD_RST  = 10'd4;
    localparam logic [RMS_W-1:0]      FULL_SCALE_RST = 10'd40;
    localparam logic [CFG_DATA_W-1:0] PERIOD_RST     = 16'd100;
    localparam logic [BYTE_W-1:0]     BRAKE_RST      = 8'd10;

    // Driver register addresses and data codes.
    localparam logic [BYTE_W-1:0] ADDR_MODE    = 8'h01;
    localparam logic [BYTE_W-1:0] ADDR_RTP     = 8'h02;
    localparam logic [BYTE_W-1:0] MODE_RTP     = 8'h05;
    localparam logic [BYTE_W-1:0] MODE_STANDBY = 8'h40;
    localparam logic [BYTE_W-1:0] LEVEL_MIN    = 8'd5;
    localparam logic [BYTE_W-1:0] LEVEL_MAX    = 8'd100;
    localparam logic [BYTE_W-1:0] DRIVE_OFF    = 8'd0;
    localparam logic [BYTE_W-1:0] COUNT_MAX    = 8'hFF;

    // Level map: (rms - thr) * 95 / (fs - thr) + 5.
    localparam int NUM_W = 17;
    localparam int DEN_W = RMS_W;
    localparam logic [6:0] LEVEL_SPAN = 7'd95;

    typedef struct packed {
        logic [RMS_W-1:0] rms_hundredths;
        logic [NOW_W-1:0] now_ms;
    } t_in_word;

    typedef struct packed {
        logic [BYTE_W-1:0] reg_addr;
        logic [BYTE_W-1:0] reg_data;
        logic              last_write;
    } t_out_word;

endpackage

>>> sv/htds_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Uses widths from htds_pkg.
module htds_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [htds_pkg::NUM_W-1:0]  i_dividend,
    input  logic [htds_pkg::DEN_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [htds_pkg::NUM_W-1:0]  o_quotient
);

    localparam int CNT_W = $clog2(htds_pkg::NUM_W + 1);

    logic [CNT_W-1:0]           r_cnt,  n_cnt;
    logic                       r_done, n_done;
    logic [htds_pkg::DEN_W-1:0] r_rem,  n_rem;
    logic [htds_pkg::DEN_W-1:0] r_den,  n_den;
    logic [htds_pkg::NUM_W-1:0] r_quo,  n_quo;

    logic [htds_pkg::DEN_W:0]   w_trial;
    logic                       w_fits;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    assign w_trial = {r_rem, r_quo[htds_pkg::NUM_W-1]};
    assign w_fits  = (w_trial >= {1'b0, r_den});

    always_comb begin
        n_cnt  = r_cnt;
        n_done = 1'b0;
        n_rem  = r_rem;
        n_den  = r_den;
        n_quo  = r_quo;
        if (i_start) begin
            n_cnt = CNT_W'(htds_pkg::NUM_W);
            n_rem = '0;
            n_den = i_divisor;
            n_quo = i_dividend;
        end else if (r_cnt != '0) begin
            n_cnt  = r_cnt - 1'b1;
            n_done = (r_cnt == CNT_W'(1));
            if (w_fits) begin
                n_rem = htds_pkg::DEN_W'(w_trial - {1'b0, r_den});
            end else begin
                n_rem = w_trial[htds_pkg::DEN_W-1:0];
            end
            n_quo = {r_quo[htds_pkg::NUM_W-2:0], w_fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_rem <= n_rem;
        r_den <= n_den;
        r_quo <= n_quo;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> sv/haptic_tremor_drive_sequencer_top.sv
// Top level of the haptic tremor drive sequencer.
// Depends on htds_pkg and the divider htds_div.
//
// The input channel takes one word per tremor sample: the RMS level in
// hundredths and a millisecond timestamp. A word is accepted when
// i_in_valid is high and o_in_stall is low. The output channel gives zero,
// one or two driver register writes per sample, each as an address/data word
// with last_write set on the final one. A word leaves when o_out_valid is high
// and i_out_stall is low.
// A sample that only needs fixed register writes shows its first word in the
// cycle after it is accepted. A sample that needs a new drive level goes
// through the restoring divider, one quotient bit per cycle, and its first
// word is shown once the divider's done flag has moved the state to S_OUT0.
// One sample is handled at a time and o_in_stall stays high until its last
// word is taken. A quiet sample in standby writes nothing and the block is
// ready again the next cycle.
// Reset loads the register defaults, puts the block in standby with a zero
// brake count and zero last-update time, and drops all pending output.
// When the receiver stalls, the current output word holds unchanged.
// Configuration is to be written only while the block is idle.
module haptic_tremor_drive_sequencer_top #(
    parameter int TIME_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  htds_pkg::t_in_word                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output htds_pkg::t_out_word               o_out_data,
    input  logic                              i_cfg_we,
    input  logic [htds_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [htds_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_OUT0 = 4'b0100,
        S_OUT1 = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers.
    logic [htds_pkg::RMS_W-1:0]      r_thr;
    logic [htds_pkg::RMS_W-1:0]      r_fs;
    logic [htds_pkg::CFG_DATA_W-1:0] r_period;
    logic [htds_pkg::BYTE_W-1:0]     r_brake_lim;

    // Sequencer state.
    logic                            r_standby, n_standby;
    logic [htds_pkg::BYTE_W-1:0]     r_brake_cnt, n_brake_cnt;
    logic [TIME_BITS-1:0]            r_last, n_last;

    // Pending output words.
    htds_pkg::t_out_word             r_w0, n_w0;
    htds_pkg::t_out_word             r_w1, n_w1;
    logic                            r_two, n_two;

    logic                            w_in_acc;
    logic                            w_out_acc;
    logic [TIME_BITS-1:0]            w_now;
    logic [TIME_BITS-1:0]            w_elapsed;
    logic                            w_active;
    logic                            w_due;
    logic [htds_pkg::BYTE_W-1:0]     w_cnt_inc;
    logic [htds_pkg::RMS_W-1:0]      w_diff;
    logic [htds_pkg::NUM_W-1:0]      w_num;
    logic [htds_pkg::DEN_W-1:0]      w_den;
    logic                            w_div_start;
    logic                            w_div_done;
    logic [htds_pkg::NUM_W-1:0]      w_quo;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT0) || (r_state == S_OUT1);
    assign o_out_data  = (r_state == S_OUT1) ? r_w1 : r_w0;

    assign w_in_acc  = i_in_valid && !o_in_stall;
    assign w_out_acc = o_out_valid && !i_out_stall;

    // Time is kept modulo 2^TIME_BITS; the timestamp is cut or zero-extended.
    assign w_now     = TIME_BITS'(i_in_data.now_ms);
    assign w_elapsed = w_now - r_last;
    assign w_active  = (i_in_data.rms_hundredths >= r_thr);
    assign w_due     = (w_elapsed >= TIME_BITS'(r_period));

    // Brake count saturates at its maximum.
    assign w_cnt_inc = (r_brake_cnt == htds_pkg::COUNT_MAX) ? r_brake_cnt
                                                            : r_brake_cnt + 1'b1;

    // Level numerator and denominator; only used when fs is above thr.
    assign w_diff = i_in_data.rms_hundredths - r_thr;
    assign w_num  = htds_pkg::NUM_W'(w_diff) * htds_pkg::NUM_W'(htds_pkg::LEVEL_SPAN);
    assign w_den  = r_fs - r_thr;

    assign w_div_start = w_in_acc && w_active && w_due && (r_fs > r_thr);

    htds_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_num),
        .i_divisor  (w_den),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    always_comb begin
        n_state     = r_state;
        n_standby   = r_standby;
        n_brake_cnt = r_brake_cnt;
        n_last      = r_last;
        n_w0        = r_w0;
        n_w1        = r_w1;
        n_two       = r_two;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (w_active) begin
                        n_standby   = 1'b0;
                        n_brake_cnt = '0;
                        n_w0.reg_addr = htds_pkg::ADDR_MODE;
                        n_w0.reg_data = htds_pkg::MODE_RTP;
                        if (w_due) begin
                            n_last          = w_now;
                            n_w0.last_write = 1'b0;
                            n_w1.reg_addr   = htds_pkg::ADDR_RTP;
                            n_w1.reg_data   = htds_pkg::LEVEL_MAX;
                            n_w1.last_write = 1'b1;
                            n_two           = 1'b1;
                            n_state         = w_div_start ? S_DIV : S_OUT0;
                        end else begin
                            n_w0.last_write = 1'b1;
                            n_two           = 1'b0;
                            n_state         = S_OUT0;
                        end
                    end else if (!r_standby) begin
                        n_brake_cnt   = w_cnt_inc;
                        n_w0.reg_addr = htds_pkg::ADDR_RTP;
                        n_w0.reg_data = htds_pkg::DRIVE_OFF;
                        n_state       = S_OUT0;
                        if (w_cnt_inc >= r_brake_lim) begin
                            n_standby       = 1'b1;
                            n_w0.last_write = 1'b0;
                            n_w1.reg_addr   = htds_pkg::ADDR_MODE;
                            n_w1.reg_data   = htds_pkg::MODE_STANDBY;
                            n_w1.last_write = 1'b1;
                            n_two           = 1'b1;
                        end else begin
                            n_w0.last_write = 1'b1;
                            n_two           = 1'b0;
                        end
                    end
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    // Below the clamp the quotient is at most 94, so its low byte suffices.
                    if (w_quo >= htds_pkg::NUM_W'(htds_pkg::LEVEL_SPAN)) begin
                        n_w1.reg_data = htds_pkg::LEVEL_MAX;
                    end else begin
                        n_w1.reg_data = w_quo[htds_pkg::BYTE_W-1:0] + htds_pkg::LEVEL_MIN;
                    end
                    n_state = S_OUT0;
                end
            end
            S_OUT0: begin
                if (w_out_acc) begin
                    n_state = r_two ? S_OUT1 : S_IDLE;
                end
            end
            S_OUT1: begin
                if (w_out_acc) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_standby   <= 1'b1;
            r_brake_cnt <= '0;
            r_last      <= '0;
            r_two       <= 1'b0;
            r_thr       <= htds_pkg::THRESHOLD_RST;
            r_fs        <= htds_pkg::FULL_SCALE_RST;
            r_period    <= htds_pkg::PERIOD_RST;
            r_brake_lim <= htds_pkg::BRAKE_RST;
        end else begin
            r_state     <= n_state;
            r_standby   <= n_standby;
            r_brake_cnt <= n_brake_cnt;
            r_last      <= n_last;
            r_two       <= n_two;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    htds_pkg::CFG_THRESHOLD:  r_thr <= i_cfg_data[htds_pkg::RMS_W-1:0];
                    htds_pkg::CFG_FULL_SCALE: r_fs  <= i_cfg_data[htds_pkg::RMS_W-1:0];
                    htds_pkg::CFG_PERIOD:     r_period <= i_cfg_data;
                    htds_pkg::CFG_BRAKE: begin
                        r_brake_lim <= i_cfg_data[htds_pkg::BYTE_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
        r_w0 <= n_w0;
        r_w1 <= n_w1;
    end

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the haptic tremor drive sequencer top level.
// Drives sample words, predicts the driver register writes, checks each one.
// Depends on htds_pkg and haptic_tremor_drive_sequencer_top.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TIME_BITS = 32;

    // Cycles the block may still be busy after its last output word.
    localparam int SETTLE_CYCLES = 25;

    // Cycles the receiver holds off during the backpressure test.
    localparam int LONG_HOLD = 300;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_stall;
    htds_pkg::t_in_word              i_in_data;
    logic                            o_out_valid;
    logic                            i_out_stall;
    htds_pkg::t_out_word             o_out_data;
    logic                            i_cfg_we;
    logic [htds_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [htds_pkg::CFG_DATA_W-1:0] i_cfg_data;

    haptic_tremor_drive_sequencer_top #(
        .TIME_BITS(TIME_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // The clock has a period of 20 ns.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Our own copy of the register settings, as the block should hold them.
    logic [htds_pkg::RMS_W-1:0]      thr_cfg;
    logic [htds_pkg::RMS_W-1:0]      fs_cfg;
    logic [htds_pkg::CFG_DATA_W-1:0] period_cfg;
    logic [htds_pkg::BYTE_W-1:0]     brake_lim;

    // Our own copy of the sequencer state.
    logic                            in_standby;
    logic [htds_pkg::BYTE_W-1:0]     brake_count;
    logic [TIME_BITS-1:0]            last_update;

    // Driver writes that the block still owes us, oldest first.
    htds_pkg::t_out_word pending_writes[$];

    int unsigned mismatches = 0;

    // When set, both sides stop idling for a stretch.
    bit no_idle = 1'b0;

    // A nonzero value asks the receiver for one long hold-off.
    int hold_cycles = 0;

    // Running millisecond clock that the stimulus advances.
    logic [htds_pkg::NOW_W-1:0] clock_ms;

    task automatic flag_mismatch(input string what);
        $display("ERROR at %0t ns: %s", $realtime, what);
        mismatches++;
    endtask

    // Works out which driver writes one accepted sample causes and queues them.
    function automatic void predict_driver_writes(input htds_pkg::t_in_word word);
        logic [TIME_BITS-1:0] now_t;
        logic [TIME_BITS-1:0] elapsed;
        int unsigned          lvl;
        now_t = TIME_BITS'(word.now_ms);
        if (word.rms_hundredths >= thr_cfg) begin
            // Drive path: leave standby and restart the brake count.
            elapsed     = now_t - last_update;
            in_standby  = 1'b0;
            brake_count = '0;
            if (elapsed >= TIME_BITS'(period_cfg)) begin
                last_update = now_t;
                if (fs_cfg <= thr_cfg) begin
                    // A scale that is not above the threshold drives full level.
                    lvl = htds_pkg::LEVEL_MAX;
                end else begin
                    lvl = (32'(word.rms_hundredths) - 32'(thr_cfg))
                        * 32'(htds_pkg::LEVEL_SPAN)
                        / (32'(fs_cfg) - 32'(thr_cfg)) + 32'(htds_pkg::LEVEL_MIN);
                    if (lvl > htds_pkg::LEVEL_MAX) begin
                        lvl = htds_pkg::LEVEL_MAX;
                    end
                end
                pending_writes.push_back({htds_pkg::ADDR_MODE, htds_pkg::MODE_RTP, 1'b0});
                pending_writes.push_back({htds_pkg::ADDR_RTP, htds_pkg::BYTE_W'(lvl), 1'b1});
            end else begin
                pending_writes.push_back({htds_pkg::ADDR_MODE, htds_pkg::MODE_RTP, 1'b1});
            end
        end else if (!in_standby) begin
            // Brake path: the count saturates rather than wrapping.
            if (brake_count < htds_pkg::COUNT_MAX) begin
                brake_count = brake_count + 1'b1;
            end
            if (brake_count >= brake_lim) begin
                in_standby = 1'b1;
                pending_writes.push_back({htds_pkg::ADDR_RTP, htds_pkg::DRIVE_OFF, 1'b0});
                pending_writes.push_back({htds_pkg::ADDR_MODE, htds_pkg::MODE_STANDBY, 1'b1});
            end else begin
                pending_writes.push_back({htds_pkg::ADDR_RTP, htds_pkg::DRIVE_OFF, 1'b1});
            end
        end
        // A quiet sample in standby causes no write at all.
    endfunction

    // Offers one sample word after a random gap and waits until it is taken.
    // The valid stays high after acceptance, so that a following word with no
    // gap goes out back to back; settle_block lowers it when the stream pauses.
    task automatic send_sample(input logic [htds_pkg::RMS_W-1:0] rms,
                               input logic [htds_pkg::NOW_W-1:0] now);
        htds_pkg::t_in_word word;
        int                 gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        word.rms_hundredths = rms;
        word.now_ms         = now;
        i_in_valid <= 1'b1;
        i_in_data  <= word;
        do @(posedge i_clk); while (o_in_stall);
        predict_driver_writes(word);
    endtask

    // Stops offering words, waits for every owed write, then lets the block
    // finish any divide that might still be running.
    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (pending_writes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [htds_pkg::CFG_IDX_W-1:0]  idx,
                             input logic [htds_pkg::CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
    endtask

    // Writes all four registers while the block is idle. Bits above a
    // register's width are dropped by the block, and so are they here.
    task automatic set_config(input logic [htds_pkg::CFG_DATA_W-1:0] thr,
                              input logic [htds_pkg::CFG_DATA_W-1:0] fs,
                              input logic [htds_pkg::CFG_DATA_W-1:0] period,
                              input logic [htds_pkg::CFG_DATA_W-1:0] brake);
        settle_block();
        write_reg(htds_pkg::CFG_THRESHOLD, thr);
        write_reg(htds_pkg::CFG_FULL_SCALE, fs);
        write_reg(htds_pkg::CFG_PERIOD, period);
        write_reg(htds_pkg::CFG_BRAKE, brake);
        i_cfg_we   <= 1'b0;
        thr_cfg    = thr[htds_pkg::RMS_W-1:0];
        fs_cfg     = fs[htds_pkg::RMS_W-1:0];
        period_cfg = period;
        brake_lim  = brake[htds_pkg::BYTE_W-1:0];
    endtask

    // The reset values of the registers and the state, checked without
    // writing any register first.
    task automatic test_reset_defaults();
        send_sample(10'd0, 32'd5);       // quiet in standby, no write
        send_sample(10'd4, 32'd100);     // at threshold: mode, then level 5
        send_sample(10'd40, 32'd150);    // period not over: mode only
        send_sample(10'd1023, 32'd250);  // level clamps at 100
        send_sample(10'd22, 32'd350);    // level 52 from the linear map
        send_sample(10'd3, 32'd360);     // below threshold: one brake write
    endtask

    // Elapsed time is taken modulo the timestamp width.
    task automatic test_time_wrap();
        set_config(16'd4, 16'd40, 16'd100, 16'd10);
        send_sample(10'd1023, 32'hFFFF_FFFF);
        send_sample(10'd512, 32'd98);    // 99 ms across the wrap: mode only
        send_sample(10'd512, 32'd99);    // exactly the period: new level
        send_sample(10'd700, 32'd0);     // backwards in time wraps to a long gap
    endtask

    task automatic test_brake_to_standby();
        set_config(16'd100, 16'd900, 16'd0, 16'd2);
        send_sample(10'd1023, 32'd1000);
        send_sample(10'd99, 32'd1001);   // first brake sample
        send_sample(10'd0, 32'd1002);    // limit reached: brake then standby mode
        send_sample(10'd0, 32'd1003);    // quiet in standby
    endtask

    // A brake limit of zero enters standby on the very first brake sample.
    task automatic test_zero_brake_limit();
        set_config(16'd10, 16'd20, 16'd0, 16'd0);
        send_sample(10'd10, 32'd2000);
        send_sample(10'd9, 32'd2001);
        send_sample(10'd9, 32'd2002);
    endtask

    // Full scale at or below the threshold drives the top level.
    task automatic test_degenerate_scale();
        set_config(16'd500, 16'd500, 16'd0, 16'd1);
        send_sample(10'd500, 32'd3000);
        set_config(16'd0, 16'd0, 16'hFFFF, 16'd1);
        send_sample(10'd0, 32'd70000);
        send_sample(10'd0, 32'd70001);
    endtask

    // With the top threshold only the largest sample drives.
    task automatic test_threshold_max();
        set_config(16'd1023, 16'd1, 16'd0, 16'd1);
        send_sample(10'd1023, 32'd80000);
        send_sample(10'd1022, 32'd80001);
    endtask

    // The receiver holds off for a long stretch while words keep coming, so
    // the block fills up and must stall its input.
    task automatic test_backpressure();
        set_config(16'd4, 16'd40, 16'd0, 16'd3);
        hold_cycles = LONG_HOLD;
        no_idle     = 1'b1;
        clock_ms    = 32'd90000;
        for (int i = 0; i < 12; i++) begin
            clock_ms = clock_ms + 32'd7;
            send_sample((i % 3 == 2) ? 10'd1 : 10'(200 + 50 * i), clock_ms);
        end
        no_idle = 1'b0;
        settle_block();
    endtask

    // Reaching the largest brake limit takes 255 quiet samples in a row.
    task automatic test_long_brake_run();
        set_config(16'd4, 16'd40, 16'd100, {8'($urandom), 8'd255});
        no_idle  = 1'b1;
        clock_ms = clock_ms + 32'd500;
        send_sample(10'd600, clock_ms);
        for (int i = 0; i < 256; i++) begin
            clock_ms = clock_ms + 32'd10;
            send_sample(10'($urandom_range(0, 3)), clock_ms);
        end
        no_idle = 1'b0;
    endtask

    // Random stream under the current settings. Most of it alternates loud
    // stretches with quiet stretches of up to three past the brake limit, at most 23,
    // with time steps around the update period; one word in ten is noise.
    task automatic run_random_stream(input int n_items);
        int                         seg_left;
        bit                         seg_loud;
        int                         quiet_max;
        logic [htds_pkg::RMS_W-1:0] rms;
        seg_left  = 0;
        seg_loud  = 1'b0;
        quiet_max = (brake_lim > 8'd20) ? 23 : int'(brake_lim) + 3;
        for (int i = 0; i < n_items; i++) begin
            if (seg_left == 0) begin
                seg_loud = ~seg_loud;
                seg_left = seg_loud ? $urandom_range(1, 12) : $urandom_range(1, quiet_max);
            end
            seg_left--;
            if ($urandom_range(0, 9) == 0) begin
                rms      = 10'($urandom_range(0, 1023));
                clock_ms = $urandom;
            end else begin
                if (seg_loud || thr_cfg == '0) begin
                    rms = 10'($urandom_range(int'(thr_cfg), 1023));
                end else begin
                    rms = 10'($urandom_range(0, int'(thr_cfg) - 1));
                end
                clock_ms = clock_ms + $urandom_range(0, 2 * int'(period_cfg) + 2);
            end
            send_sample(rms, clock_ms);
        end
    endtask

    // Random settings; with junk_bits the unused high bits of each write are
    // randomized as well.
    task automatic test_random_mix(input int n_items, input bit junk_bits);
        logic [5:0] hi10;
        logic [7:0] hi8;
        hi10 = junk_bits ? 6'($urandom) : 6'd0;
        hi8  = junk_bits ? 8'($urandom) : 8'd0;
        set_config({hi10, 10'($urandom_range(0, 500))}, {hi10, 10'($urandom_range(0, 1023))},
                   16'($urandom_range(0, 300)), {hi8, 8'($urandom_range(1, 8))});
        run_random_stream(n_items);
    endtask

    // The extreme settings, one of them with no idling on either side.
    task automatic test_random_corners();
        set_config(16'd4, 16'd40, 16'd100, 16'd10);
        run_random_stream(70);
        set_config(16'd0, 16'd1023, 16'd0, 16'd1);
        no_idle = 1'b1;
        run_random_stream(40);
        no_idle = 1'b0;
        set_config(16'd1023, 16'd1, 16'hFFFF, 16'd255);
        run_random_stream(40);
    endtask

    // Receiver: for every output word it draws a random stall, none while no_idle is set,
    // and once per request it holds off for the long stretch.
    initial begin : drain_writes
        int n;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_cycles > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
            end
            n = no_idle ? 0 : $urandom_range(0, 8);
            i_out_stall <= (n > 0);
            if (n > 0) begin
                repeat (n) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Every word taken from the output is compared with the oldest owed write.
    always @(posedge i_clk) begin : check_writes
        htds_pkg::t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_writes.size() == 0) begin
                flag_mismatch($sformatf("unexpected write addr %02h data %02h last %0b",
                                        o_out_data.reg_addr, o_out_data.reg_data,
                                        o_out_data.last_write));
            end else begin
                want = pending_writes.pop_front();
                if (o_out_data.reg_addr !== want.reg_addr) begin
                    flag_mismatch($sformatf("reg_addr %02h, expected %02h",
                                            o_out_data.reg_addr, want.reg_addr));
                end
                if (o_out_data.reg_data !== want.reg_data) begin
                    flag_mismatch($sformatf("reg_data %02h, expected %02h (addr %02h)",
                                            o_out_data.reg_data, want.reg_data, want.reg_addr));
                end
                if (o_out_data.last_write !== want.last_write) begin
                    flag_mismatch($sformatf("last_write %0b, expected %0b",
                                            o_out_data.last_write, want.last_write));
                end
            end
        end
    end

    // Main sequence: reset once, directed tests, then the random part.
    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_out_stall <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= htds_pkg::CFG_THRESHOLD;
        i_cfg_data  <= '0;
        thr_cfg     = htds_pkg::THRESHOLD_RST;
        fs_cfg      = htds_pkg::FULL_SCALE_RST;
        period_cfg  = htds_pkg::PERIOD_RST;
        brake_lim   = htds_pkg::BRAKE_RST;
        in_standby  = 1'b1;
        brake_count = '0;
        last_update = '0;
        clock_ms    = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_time_wrap();
        test_brake_to_standby();
        test_zero_brake_limit();
        test_degenerate_scale();
        test_threshold_max();
        test_backpressure();
        test_long_brake_run();
        test_random_mix(70, 1'b0);
        test_random_mix(70, 1'b1);
        test_random_corners();

        // Drain everything, then allow for the longest divide before judging.
        i_in_valid <= 1'b0;
        while (pending_writes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES + 5) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog: a correct run needs well under a tenth of this time.
    initial begin
        #10ms;
        $display("ERROR: run did not finish in time");
        $display("Mismatches found");
        $finish;
    end

endmodule
